### sv/mcc_pkg.sv
// ============================================================================
// mcc_pkg
// Shared types and constants of the multichannel convolution engine.
// ============================================================================
package mcc_pkg;

    localparam int MAX_CHANNELS = 64;
    localparam int MAX_SIDE     = 32;
    localparam int MAX_KERNELS  = 64;
    localparam int MAX_KSIZE    = 3;
    localparam int KAREA        = MAX_KSIZE * MAX_KSIZE;

    localparam int CH_W   = $clog2(MAX_CHANNELS);
    localparam int SIDE_W = $clog2(MAX_SIDE);
    localparam int KER_W  = $clog2(MAX_KERNELS);
    localparam int TAP_W  = $clog2(KAREA);
    localparam int FADDR_W = CH_W + 2 * SIDE_W;
    localparam int WADDR_W = KER_W + CH_W + TAP_W;
    localparam int ACC_W   = 40;

    localparam logic [1:0] CMD_WGT  = 2'd0;
    localparam logic [1:0] CMD_FEAT = 2'd1;
    localparam logic [1:0] CMD_COMP = 2'd2;

    localparam logic [2:0] REG_CH  = 3'd0;
    localparam logic [2:0] REG_H   = 3'd1;
    localparam logic [2:0] REG_W   = 3'd2;
    localparam logic [2:0] REG_K   = 3'd3;
    localparam logic [2:0] REG_PAD = 3'd4;
    localparam logic [2:0] REG_NK  = 3'd5;

    typedef struct packed {
        logic                bad;
        logic [KER_W-1:0]    kidx;
        logic [SIDE_W-1:0]   row;
        logic [SIDE_W-1:0]   col;
    } job_t;

endpackage

### sv/mcc_ram.sv
// ============================================================================
// mcc_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ============================================================================
module mcc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### sv/mcc_front.sv
// ============================================================================
// mcc_front
// Accepts transactions, performs store writes and queues range-checked jobs.
// ============================================================================
module mcc_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              cmd,
    input  logic [5:0]              kernel_idx,
    input  logic [5:0]              channel,
    input  logic [4:0]              row,
    input  logic [4:0]              col,
    input  logic signed [15:0]      data_value,
    input  logic [6:0]              nk_lim,
    input  logic [6:0]              oh_lim,
    input  logic [6:0]              ow_lim,
    input  logic                    back_busy,
    output logic                    fwe,
    output logic [mcc_pkg::FADDR_W-1:0] fwaddr,
    output logic [15:0]             fwdata,
    output logic                    wwe,
    output logic [mcc_pkg::WADDR_W-1:0] wwaddr,
    output logic [7:0]              wwdata,
    output logic                    job_valid,
    output mcc_pkg::job_t           job,
    input  logic                    job_take
);
    import mcc_pkg::*;

    job_t q_reg [2];
    logic [1:0] cnt_reg;
    logic       rp_reg, wp_reg;
    logic       acc, push;
    job_t       nj;

    // A write waits until every queued or running compute has read the stores.
    assign in_stall  = (cnt_reg == 2'd2) || ((cmd != CMD_COMP) && (job_valid || back_busy));
    assign acc       = in_valid && !in_stall;
    assign push      = acc && (cmd == CMD_COMP);
    assign job_valid = (cnt_reg != 2'd0);
    assign job       = q_reg[rp_reg];

    always_comb
    begin
        nj.kidx = kernel_idx;
        nj.row  = row;
        nj.col  = col;
        nj.bad  = ({1'b0, kernel_idx} >= nk_lim) || ({2'b0, row} >= oh_lim)
                  || ({2'b0, col} >= ow_lim);
    end

    assign fwe    = acc && (cmd == CMD_FEAT);
    assign fwaddr = {channel, row, col};
    assign fwdata = data_value;
    assign wwe    = acc && (cmd == CMD_WGT) && (row < 5'd3) && (col < 5'd3);
    assign wwaddr = {kernel_idx, channel, {2'b0, row[1:0]} * 4'd3 + {2'b0, col[1:0]}};
    assign wwdata = (data_value > 16'sd127) ? 8'sd127 :
                    (data_value < -16'sd128) ? -8'sd128 : data_value[7:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rp_reg  <= 1'b0;
            wp_reg  <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                q_reg[wp_reg] <= nj;
                wp_reg <= !wp_reg;
            end
            if (job_take)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, job_take};
        end
    end
endmodule

### sv/mcc_back.sv
// ============================================================================
// mcc_back
// Executes compute jobs: one channel of the window per cycle, nine taps wide.
// ============================================================================
module mcc_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    job_valid,
    input  mcc_pkg::job_t           job,
    output logic                    job_take,
    output logic                    busy,
    input  logic [6:0]              nc_lim,
    input  logic [5:0]              h_lim,
    input  logic [5:0]              w_lim,
    input  logic [1:0]              k_lim,
    input  logic                    pad,
    output logic [mcc_pkg::FADDR_W-1:0] fraddr [mcc_pkg::KAREA],
    input  logic [15:0]             frdata [mcc_pkg::KAREA],
    output logic [mcc_pkg::CH_W+mcc_pkg::KER_W-1:0] wraddr,
    input  logic [8*mcc_pkg::KAREA-1:0] wrdata,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [15:0]      conv_value,
    output logic                    saturated,
    output logic                    status
);
    import mcc_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN, S_DONE} state_t;

    state_t state_reg;
    job_t   j_reg;
    logic [CH_W:0] c_reg;
    logic          v1_reg, v2_reg, last1_reg, last2_reg;
    logic [KAREA-1:0] m1_reg, m_cur;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [23:0] p_reg [KAREA];
    logic out_valid_reg;
    logic signed [15:0] val_reg;
    logic sat_reg, st_reg;
    logic signed [ACC_W-1:0] psum, accn;

    assign job_take = job_valid && (state_reg == S_IDLE) && !out_valid_reg;
    assign busy     = (state_reg != S_IDLE);
    assign wraddr   = {j_reg.kidx, c_reg[CH_W-1:0]};

    always_comb
    begin
        for (int t = 0; t < KAREA; t++)
        begin
            logic signed [7:0] ir, ic;
            ir = $signed({3'b0, j_reg.row}) + 8'(t / 3) - $signed({7'b0, pad});
            ic = $signed({3'b0, j_reg.col}) + 8'(t % 3) - $signed({7'b0, pad});
            m_cur[t] = (8'(t / 3) < {6'b0, k_lim}) && (8'(t % 3) < {6'b0, k_lim})
                       && (ir >= 0) && (ir < $signed({2'b0, h_lim}))
                       && (ic >= 0) && (ic < $signed({2'b0, w_lim}));
            fraddr[t] = {c_reg[CH_W-1:0], ir[SIDE_W-1:0], ic[SIDE_W-1:0]};
        end
    end

    always_comb
    begin
        psum = '0;
        for (int t = 0; t < KAREA; t++)
        begin
            psum = psum + ACC_W'(p_reg[t]);
        end
        accn = acc_reg + (v2_reg ? psum : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            last1_reg     <= 1'b0;
            last2_reg     <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            v1_reg    <= 1'b0;
            last1_reg <= 1'b0;
            v2_reg    <= v1_reg;
            last2_reg <= last1_reg;
            m1_reg    <= m_cur;
            for (int t = 0; t < KAREA; t++)
            begin
                p_reg[t] <= (v1_reg && m1_reg[t]) ?
                    24'($signed(frdata[t]) * $signed(wrdata[8*t +: 8])) : '0;
            end
            acc_reg <= accn;
            case (state_reg)
                S_IDLE:
                begin
                    if (job_take)
                    begin
                        j_reg   <= job;
                        c_reg   <= '0;
                        acc_reg <= '0;
                        if (job.bad)
                        begin
                            val_reg       <= '0;
                            sat_reg       <= 1'b0;
                            st_reg        <= 1'b1;
                            out_valid_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= S_RUN;
                        end
                    end
                end
                S_RUN:
                begin
                    v1_reg    <= 1'b1;
                    last1_reg <= (c_reg + 1'b1 == nc_lim);
                    c_reg     <= c_reg + 1'b1;
                    if (c_reg + 1'b1 == nc_lim)
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    if (last2_reg)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    st_reg  <= 1'b0;
                    sat_reg <= (acc_reg[ACC_W-1:22] != {18{acc_reg[ACC_W-1]}});
                    if (acc_reg[ACC_W-1:22] == {18{acc_reg[ACC_W-1]}})
                    begin
                        val_reg <= acc_reg[22:7];
                    end
                    else
                    begin
                        val_reg <= acc_reg[ACC_W-1] ? -16'sd32768 : 16'sd32767;
                    end
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign conv_value = val_reg;
    assign saturated  = sat_reg;
    assign status     = st_reg;
endmodule

### sv/multichannel_conv2d_engine.sv
// ============================================================================
// multichannel_conv2d_engine
// Zero-padded stride-1 multichannel 2-D convolution with fixed-point output.
// ============================================================================
// A write transaction is written to the stores when it is accepted. The
// execution unit computes the result of a compute transaction one input
// channel per cycle, with all nine window taps read in parallel from nine
// feature RAM copies and one nine-weight-wide weight RAM row. A two-entry
// queue lets further computes enter while one is executing; a write waits
// until every queued compute has finished, so each compute sees the stores
// as they stood when it was accepted. An out-of-range compute returns
// status 1 with a zero result.
module multichannel_conv2d_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [6:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         cmd,
    input  logic [5:0]         kernel_idx,
    input  logic [5:0]         channel,
    input  logic [4:0]         row,
    input  logic [4:0]         col,
    input  logic signed [15:0] data_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] conv_value,
    output logic               saturated,
    output logic               status
);
    import mcc_pkg::*;

    logic [6:0] ch_reg, nk_reg;
    logic [5:0] h_reg, w_reg;
    logic [1:0] k_reg;
    logic       pad_reg;
    logic [6:0] nc_lim, nk_lim, oh_lim, ow_lim;
    logic [6:0] oh_sum, ow_sum;
    logic [5:0] h_lim, w_lim;
    logic [1:0] k_lim;
    logic       fwe, wwe, job_valid, job_take, back_busy;
    logic [FADDR_W-1:0] fwaddr;
    logic [WADDR_W-1:0] wwaddr;
    logic [15:0] fwdata;
    logic [7:0]  wwdata;
    job_t        job;
    logic [FADDR_W-1:0] fraddr [KAREA];
    logic [15:0] frdata [KAREA];
    logic [CH_W+KER_W-1:0] wraddr;
    logic [8*KAREA-1:0] wrdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_reg  <= 7'd3;
            h_reg   <= 6'd32;
            w_reg   <= 6'd32;
            k_reg   <= 2'd3;
            pad_reg <= 1'b1;
            nk_reg  <= 7'd64;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CH:  ch_reg  <= cfg_data;
                REG_H:   h_reg   <= cfg_data[5:0];
                REG_W:   w_reg   <= cfg_data[5:0];
                REG_K:   k_reg   <= cfg_data[1:0];
                REG_PAD: pad_reg <= cfg_data[0];
                REG_NK:  nk_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        nc_lim = (ch_reg == 0) ? 7'd1 : (ch_reg > 7'd64) ? 7'd64 : ch_reg;
        nk_lim = (nk_reg == 0) ? 7'd1 : (nk_reg > 7'd64) ? 7'd64 : nk_reg;
        h_lim  = (h_reg == 0) ? 6'd1 : (h_reg > 6'd32) ? 6'd32 : h_reg;
        w_lim  = (w_reg == 0) ? 6'd1 : (w_reg > 6'd32) ? 6'd32 : w_reg;
        k_lim  = (k_reg == 0) ? 2'd1 : k_reg;
        oh_sum = {1'b0, h_lim} + {5'b0, pad_reg, 1'b0} + 7'd1;
        ow_sum = {1'b0, w_lim} + {5'b0, pad_reg, 1'b0} + 7'd1;
        oh_lim = (oh_sum > {5'b0, k_lim}) ? oh_sum - {5'b0, k_lim} : 7'd0;
        ow_lim = (ow_sum > {5'b0, k_lim}) ? ow_sum - {5'b0, k_lim} : 7'd0;
    end

    mcc_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .kernel_idx(kernel_idx), .channel(channel), .row(row), .col(col),
        .data_value(data_value), .nk_lim(nk_lim), .oh_lim(oh_lim), .ow_lim(ow_lim),
        .back_busy(back_busy),
        .fwe(fwe), .fwaddr(fwaddr), .fwdata(fwdata), .wwe(wwe), .wwaddr(wwaddr),
        .wwdata(wwdata), .job_valid(job_valid), .job(job), .job_take(job_take)
    );

    for (genvar t = 0; t < KAREA; t++)
    begin : g_feat
        mcc_ram #(.WIDTH(16), .DEPTH(1 << FADDR_W)) u_fram (
            .clk(clk), .we(fwe), .waddr(fwaddr), .wdata(fwdata),
            .raddr(fraddr[t]), .rdata(frdata[t])
        );
        mcc_ram #(.WIDTH(8), .DEPTH(1 << (CH_W + KER_W))) u_wram (
            .clk(clk), .we(wwe && (wwaddr[TAP_W-1:0] == TAP_W'(t))),
            .waddr(wwaddr[WADDR_W-1:TAP_W]), .wdata(wwdata),
            .raddr(wraddr), .rdata(wrdata[8*t +: 8])
        );
    end

    mcc_back u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(job_valid), .job(job), .job_take(job_take),
        .busy(back_busy),
        .nc_lim(nc_lim), .h_lim(h_lim), .w_lim(w_lim), .k_lim(k_lim), .pad(pad_reg),
        .fraddr(fraddr), .frdata(frdata), .wraddr(wraddr), .wrdata(wrdata),
        .out_valid(out_valid), .out_stall(out_stall), .conv_value(conv_value),
        .saturated(saturated), .status(status)
    );
endmodule
